// ===== hw/rtl/i2cwd_pkg.sv =====
// Shared types and constants for the write-only two-wire display master.
// No dependencies; every other file in hw/rtl refers to this package.
package i2cwd_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned PayloadW = 8;
  localparam int unsigned AddrW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CmdW-1:0] {
    CmdTick    = 2'd0,
    CmdCommand = 2'd1,
    CmdData    = 2'd2,
    CmdRecover = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFirstAddr  = 2'd0,
    CfgSecondAddr = 2'd1,
    CfgSecondEn   = 2'd2
  } cfg_idx_e;

  localparam logic [AddrW-1:0]    FirstAddrReset  = 8'h78;
  localparam logic [AddrW-1:0]    SecondAddrReset = 8'h7A;
  localparam logic                SecondEnReset   = 1'b1;
  localparam logic [PayloadW-1:0] CtrlCommand     = 8'h00;
  localparam logic [PayloadW-1:0] CtrlData        = 8'h40;
  localparam int unsigned         RecoveryClocks  = 9;

  typedef struct packed {
    cmd_e                command;
    logic [PayloadW-1:0] payload;
  } item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic accepted;
    logic finished;
  } result_t;

  typedef struct packed {
    logic [AddrW-1:0] first_address_byte;
    logic [AddrW-1:0] second_address_byte;
    logic             second_enable;
  } cfg_t;

endpackage

// ===== hw/rtl/i2cwd_if.sv =====
// Handshake interfaces for the request, result and register write channels.
// Depends on i2cwd_pkg for field widths.
interface i2cwd_req_if;
  logic                            valid;
  logic                            ready;
  logic [i2cwd_pkg::CmdW-1:0]      command;
  logic [i2cwd_pkg::PayloadW-1:0]  payload;
  modport source (output valid, output command, output payload, input ready);
  modport sink (input valid, input command, input payload, output ready);
endinterface

interface i2cwd_res_if;
  logic valid;
  logic ready;
  logic scl_level;
  logic sda_level;
  logic busy_res;
  logic accepted;
  logic finished;
  modport source (output valid, output scl_level, output sda_level, output busy_res,
                  output accepted, output finished, input ready);
  modport sink (input valid, input scl_level, input sda_level, input busy_res,
                input accepted, input finished, output ready);
endinterface

interface i2cwd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [i2cwd_pkg::CfgIdxW-1:0]    index;
  logic [i2cwd_pkg::CfgDataW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/i2cwd_seq.sv =====
// Phase sequencer: holds the bus transfer state and works out one result per word.
// Depends on i2cwd_pkg.
module i2cwd_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  i2cwd_pkg::item_t    item_i,
  input  i2cwd_pkg::cfg_t     cfg_i,
  output i2cwd_pkg::result_t  res_o
);

  localparam logic [1:0] SegStart = 2'd0;
  localparam logic [1:0] SegByte  = 2'd1;
  localparam logic [1:0] SegClk   = 2'd2;
  localparam logic [1:0] SegStop  = 2'd3;

  logic                                busy_q, busy_d;
  i2cwd_pkg::cmd_e                     kind_q, kind_d;
  logic [1:0]                          seg_q, seg_d;
  logic [1:0]                          sub_q, sub_d;
  logic [3:0]                          bit_q, bit_d;
  logic [1:0]                          byte_q, byte_d;
  logic                                pass_q, pass_d;
  logic [i2cwd_pkg::PayloadW-1:0]      pay_q, pay_d;
  logic                                scl_q, scl_d;
  logic                                sda_q, sda_d;
  logic                                lvl_scl, lvl_sda;
  logic [i2cwd_pkg::PayloadW-1:0]      tx_byte;
  logic [i2cwd_pkg::PayloadW-1:0]      tx_shift;
  logic                                accepted, finished;

  always_comb begin
    case (byte_q)
      2'd0:    tx_byte = pass_q ? cfg_i.second_address_byte : cfg_i.first_address_byte;
      2'd1:    tx_byte = (kind_q == i2cwd_pkg::CmdCommand) ? i2cwd_pkg::CtrlCommand
                                                           : i2cwd_pkg::CtrlData;
      default: tx_byte = pay_q;
    endcase
    tx_shift = tx_byte << bit_q[2:0];
  end

  always_comb begin
    unique case (seg_q)
      SegStart: begin
        lvl_scl = (sub_q != 2'd2);
        lvl_sda = (sub_q == 2'd0);
      end
      SegByte: begin
        lvl_scl = (sub_q == 2'd1);
        lvl_sda = bit_q[3] ? 1'b1 : tx_shift[i2cwd_pkg::PayloadW-1];
      end
      SegClk: begin
        lvl_scl = (sub_q == 2'd0);
        lvl_sda = 1'b1;
      end
      default: begin
        lvl_scl = (sub_q != 2'd0);
        lvl_sda = (sub_q == 2'd2);
      end
    endcase
  end

  always_comb begin
    busy_d   = busy_q;
    kind_d   = kind_q;
    seg_d    = seg_q;
    sub_d    = sub_q;
    bit_d    = bit_q;
    byte_d   = byte_q;
    pass_d   = pass_q;
    pay_d    = pay_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    accepted = 1'b0;
    finished = 1'b0;
    if (fire_i) begin
      if (item_i.command != i2cwd_pkg::CmdTick) begin
        if (!busy_q) begin
          accepted = 1'b1;
          busy_d   = 1'b1;
          kind_d   = item_i.command;
          seg_d    = (item_i.command == i2cwd_pkg::CmdRecover) ? SegClk : SegStart;
          sub_d    = 2'd0;
          bit_d    = 4'd0;
          byte_d   = 2'd0;
          pass_d   = 1'b0;
          pay_d    = (item_i.command == i2cwd_pkg::CmdRecover) ? '0 : item_i.payload;
        end
      end else if (busy_q) begin
        scl_d = lvl_scl;
        sda_d = lvl_sda;
        unique case (seg_q)
          SegStart: begin
            if (sub_q == 2'd2) begin
              seg_d  = SegByte;
              sub_d  = 2'd0;
              bit_d  = 4'd0;
              byte_d = 2'd0;
            end else begin
              sub_d = sub_q + 2'd1;
            end
          end
          SegByte: begin
            if (sub_q == 2'd2) begin
              sub_d = 2'd0;
              if (bit_q[3]) begin
                bit_d = 4'd0;
                if (byte_q == 2'd2) begin
                  seg_d = SegStop;
                end else begin
                  byte_d = byte_q + 2'd1;
                end
              end else begin
                bit_d = bit_q + 4'd1;
              end
            end else begin
              sub_d = sub_q + 2'd1;
            end
          end
          SegClk: begin
            if (sub_q == 2'd1) begin
              sub_d = 2'd0;
              if (bit_q == 4'(i2cwd_pkg::RecoveryClocks - 1)) begin
                seg_d = SegStop;
                bit_d = 4'd0;
              end else begin
                bit_d = bit_q + 4'd1;
              end
            end else begin
              sub_d = 2'd1;
            end
          end
          default: begin
            if (sub_q == 2'd2) begin
              sub_d = 2'd0;
              seg_d = SegStart;
              if (kind_q != i2cwd_pkg::CmdRecover && !pass_q && cfg_i.second_enable) begin
                pass_d = 1'b1;
              end else begin
                finished = 1'b1;
                busy_d   = 1'b0;
                kind_d   = i2cwd_pkg::CmdTick;
                pass_d   = 1'b0;
              end
            end else begin
              sub_d = sub_q + 2'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= i2cwd_pkg::CmdTick;
      seg_q  <= SegStart;
      sub_q  <= 2'd0;
      bit_q  <= 4'd0;
      byte_q <= 2'd0;
      pass_q <= 1'b0;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
    end else begin
      busy_q <= busy_d;
      kind_q <= kind_d;
      seg_q  <= seg_d;
      sub_q  <= sub_d;
      bit_q  <= bit_d;
      byte_q <= byte_d;
      pass_q <= pass_d;
      scl_q  <= scl_d;
      sda_q  <= sda_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  assign res_o.scl_level = scl_d;
  assign res_o.sda_level = sda_d;
  assign res_o.busy_res  = busy_d;
  assign res_o.accepted  = accepted;
  assign res_o.finished  = finished;

  a_finish_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished |=> !busy_q && !pass_q)
    else $error("sequence finished but sequencer still busy");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted |-> !busy_q ##1 busy_q)
    else $error("request taken while a sequence was running");

  a_bit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> bit_q <= 4'd8)
    else $error("bit counter out of range");

  a_idle_lines_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q && !accepted |=> $stable(scl_q) && $stable(sda_q))
    else $error("bus lines moved while idle");

endmodule

// ===== hw/rtl/i2c_write_only_display_master_unit.sv =====
// Top level of the write-only two-wire display master: register file and word pipeline.
// Depends on i2cwd_pkg, the interfaces in i2cwd_if.sv and i2cwd_seq.
//
//   channel  direction  fields
//   req_i    in         command, payload
//   res_o    out        scl_level, sda_level, busy_res, accepted, finished
//   cfg_i    in         index, data (register write, always ready)
//
// One word is taken per cycle unless the result register stalls; each word is held in the
// input register, then its result in the result register, with the sequencer logic between.
// Reset leaves both lines high, the sequencer idle and the registers at 0x78, 0x7A, 1.
// A stalled result register holds the input register, which in turn drops req_i.ready.
module i2c_write_only_display_master_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cwd_req_if.sink    req_i,
  i2cwd_res_if.source  res_o,
  i2cwd_cfg_if.sink    cfg_i
);

  logic                   in_valid_q;
  i2cwd_pkg::item_t       in_item_q;
  logic                   out_valid_q;
  i2cwd_pkg::result_t     out_res_q;
  i2cwd_pkg::result_t     seq_res;
  i2cwd_pkg::cfg_t        cfg_q;
  logic                   out_free;
  logic                   fire;

  assign out_free    = !out_valid_q || res_o.ready;
  assign fire        = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || fire;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q.first_address_byte  <= i2cwd_pkg::FirstAddrReset;
      cfg_q.second_address_byte <= i2cwd_pkg::SecondAddrReset;
      cfg_q.second_enable       <= i2cwd_pkg::SecondEnReset;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          i2cwd_pkg::CfgFirstAddr:  cfg_q.first_address_byte  <= cfg_i.data;
          i2cwd_pkg::CfgSecondAddr: cfg_q.second_address_byte <= cfg_i.data;
          i2cwd_pkg::CfgSecondEn:   cfg_q.second_enable       <= cfg_i.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_item_q.command <= i2cwd_pkg::cmd_e'(req_i.command);
      in_item_q.payload <= req_i.payload;
    end
    if (fire) begin
      out_res_q <= seq_res;
    end
  end

  i2cwd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (seq_res)
  );

  assign res_o.valid     = out_valid_q;
  assign res_o.scl_level = out_res_q.scl_level;
  assign res_o.sda_level = out_res_q.sda_level;
  assign res_o.busy_res  = out_res_q.busy_res;
  assign res_o.accepted  = out_res_q.accepted;
  assign res_o.finished  = out_res_q.finished;

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_item_q))
    else $error("input register lost a word during a stall");

  a_fire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed word did not reach the result register");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |-> !req_i.ready)
    else $error("ready raised while the pipeline is full");

endmodule
